// ===== hw/rtl/ssf_pkg.sv =====
// Shared types, constants and helpers for the Q31 state-space filter.
// No dependencies; every other file of the block refers to it by scoped names.
package ssf_pkg;

  // Default matrix sizes
  localparam int STATE_ORDER  = 7;
  localparam int IN_CHANNELS  = 2;
  localparam int OUT_CHANNELS = 2;

  // Coefficient store geometry
  localparam int STORE_DEPTH = 128;
  localparam int ADDR_W      = 7;
  localparam int DATA_W      = 32;
  localparam int ACC_W       = 64;

  // Command codes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Matrix-vector row kinds
  localparam logic [1:0] KIND_C = 2'd0;
  localparam logic [1:0] KIND_A = 2'd1;
  localparam logic [1:0] KIND_B = 2'd2;

  // Control that travels with each MAC operand pair
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

  // Q31 add with saturation
  function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) begin
      sat_add = s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      sat_add = s[DATA_W-1:0];
    end
  endfunction

endpackage

// ===== hw/rtl/ssf_if.sv =====
// Valid/ready channel interfaces for the state-space filter.
// Depends on ssf_pkg for field widths.
interface ssf_in_if;
  logic                                valid;
  logic                                ready;
  logic                                opcode;
  logic        [ssf_pkg::ADDR_W-1:0]   coef_index;
  logic signed [ssf_pkg::DATA_W-1:0]   coef_value;
  logic signed [ssf_pkg::DATA_W-1:0]   right_in;
  logic signed [ssf_pkg::DATA_W-1:0]   left_in;

  modport source (output valid, opcode, coef_index, coef_value, right_in, left_in,
                  input ready);
  modport sink   (input valid, opcode, coef_index, coef_value, right_in, left_in,
                  output ready);
endinterface

interface ssf_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [ssf_pkg::DATA_W-1:0]   right_out;
  logic signed [ssf_pkg::DATA_W-1:0]   left_out;

  modport source (output valid, right_out, left_out, input ready);
  modport sink   (input valid, right_out, left_out, output ready);
endinterface

// ===== hw/rtl/ssf_coef_mem.sv =====
// Coefficient store: 128 Q31 words, one write and one registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset. Uses ssf_pkg.
module ssf_coef_mem (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               we,
  input  logic        [ssf_pkg::ADDR_W-1:0]  waddr,
  input  logic        [ssf_pkg::DATA_W-1:0]  wdata,
  input  logic                               re,
  input  logic        [ssf_pkg::ADDR_W-1:0]  raddr,
  output logic signed [ssf_pkg::DATA_W-1:0]  rdata
);

  logic [ssf_pkg::DATA_W-1:0] mem [ssf_pkg::STORE_DEPTH];
  logic [ssf_pkg::STORE_DEPTH-1:0] vld_r;
  logic [ssf_pkg::DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= vld_r[raddr] ? mem[raddr] : '0;
    end
  end

  assign rdata = $signed(rdata_r);

endmodule

// ===== hw/rtl/ssf_mac.sv =====
// Shared multiply-accumulate unit: registered 32x32 product, 64-bit wrapping
// accumulator, row result taken as bits 62..31. Uses ssf_pkg::mac_ctl_t.
module ssf_mac (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ssf_pkg::mac_ctl_t                  ctl,
  input  logic signed [ssf_pkg::DATA_W-1:0]  coef,
  input  logic signed [ssf_pkg::DATA_W-1:0]  opnd,
  output logic                               res_valid,
  output logic        [ssf_pkg::DATA_W-1:0]  res
);

  ssf_pkg::mac_ctl_t                 ctl2_r;
  logic signed [ssf_pkg::ACC_W-1:0]  prod_r;
  logic        [ssf_pkg::ACC_W-1:0]  acc_r;
  logic        [ssf_pkg::ACC_W-1:0]  acc_sum;
  logic        [ssf_pkg::DATA_W-1:0] res_r;
  logic                              res_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r      <= '0;
      res_valid_r <= 1'b0;
    end else begin
      ctl2_r      <= ctl;
      res_valid_r <= ctl2_r.valid && ctl2_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.valid) begin
      prod_r <= 64'(coef) * 64'(opnd);
    end
  end

  // Start a fresh sum on the first term of a row
  assign acc_sum = (ctl2_r.first ? '0 : acc_r) + $unsigned(prod_r);

  always_ff @(posedge clk) begin
    if (ctl2_r.valid) begin
      acc_r <= acc_sum;
      if (ctl2_r.last) begin
        res_r <= acc_sum[62:31];
      end
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

// ===== hw/rtl/state_space_filter_q31.sv =====
// Top level of the Q31 state-space filter: sequencer, state registers, output register.
// Depends on ssf_pkg, ssf_if, ssf_coef_mem and ssf_mac.

// A write command (opcode 0) stores one coefficient word and is done in the cycle
// it transfers. A sample command (opcode 1) runs every multiply-accumulate through
// one shared MAC unit, one term per cycle: OUT_CHANNELS*STATE_ORDER terms for
// y = C*x, then per state row STATE_ORDER terms of A*x and IN_CHANNELS terms of B*u,
// 77 terms at the default sizes. After the store read, product and accumulate stages
// and the retire step, the commit step ends the sample; after a sample transfers,
// in_if.ready stays low through the commit step. The result shows on out_if in the same
// cycle that in_if.ready rises again, so the next item can transfer in that cycle.
// The result sits in an output register, so write commands are taken while it waits;
// a sample that finishes while the previous result is still untaken holds in its
// commit step until that transfer.
module state_space_filter_q31 #(
  parameter int STATE_ORDER  = ssf_pkg::STATE_ORDER,
  parameter int IN_CHANNELS  = ssf_pkg::IN_CHANNELS,
  parameter int OUT_CHANNELS = ssf_pkg::OUT_CHANNELS
) (
  input  logic       clk,
  input  logic       rst_n,
  ssf_in_if.sink     in_if,
  ssf_out_if.source  out_if
);

  localparam int KW = (STATE_ORDER > 1) ? $clog2(STATE_ORDER) : 1;
  localparam logic [ssf_pkg::ADDR_W-1:0] BASE_B =
    ssf_pkg::ADDR_W'(STATE_ORDER * STATE_ORDER);
  localparam logic [ssf_pkg::ADDR_W-1:0] BASE_C =
    ssf_pkg::ADDR_W'(STATE_ORDER * STATE_ORDER + STATE_ORDER * IN_CHANNELS);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state_r, state_nxt;

  logic in_xfer, out_xfer, wr_cmd, smp_cmd;
  logic commit;

  // Issue side
  logic [1:0]                  kind_r;
  logic [KW-1:0]               row_r, k_r;
  logic [ssf_pkg::ADDR_W-1:0]  a_ptr_r, b_ptr_r, c_ptr_r, iss_addr;
  logic                        issue, iss_last, row_end_b;
  logic [ssf_pkg::DATA_W-1:0]  iss_opnd, op1_r;
  ssf_pkg::mac_ctl_t           ctl1_r;

  // Retire side
  logic [1:0]                  ret_kind_r;
  logic [KW-1:0]               ret_row_r;
  logic                        res_valid;
  logic [ssf_pkg::DATA_W-1:0]  res;
  logic signed [ssf_pkg::DATA_W-1:0] coef_rd;

  // Datapath storage
  logic [ssf_pkg::DATA_W-1:0]  x_r  [STATE_ORDER];
  logic [ssf_pkg::DATA_W-1:0]  nx_r [STATE_ORDER];
  logic [ssf_pkg::DATA_W-1:0]  y_r  [2];
  logic [ssf_pkg::DATA_W-1:0]  ax_r, u0_r, u1_r;
  logic [ssf_pkg::DATA_W-1:0]  right_out_r, left_out_r;
  logic                        out_valid_r;

  assign in_if.ready = (state_r == S_IDLE);
  assign in_xfer     = in_if.valid && in_if.ready;
  assign wr_cmd      = in_xfer && (in_if.opcode == ssf_pkg::OP_WRITE);
  assign smp_cmd     = in_xfer && (in_if.opcode == ssf_pkg::OP_SAMPLE);
  assign out_xfer    = out_valid_r && out_if.ready;
  assign commit      = (state_r == S_DONE) && (!out_valid_r || out_if.ready);

  // ---------------------------------------------------------------- issue
  assign issue = (state_r == S_RUN);

  always_comb begin
    case (kind_r)
      ssf_pkg::KIND_C: iss_addr = c_ptr_r;
      ssf_pkg::KIND_A: iss_addr = a_ptr_r;
      default:         iss_addr = b_ptr_r;
    endcase
  end

  always_comb begin
    if (kind_r == ssf_pkg::KIND_B) begin
      iss_last = (k_r == KW'(IN_CHANNELS - 1));
      iss_opnd = (k_r == '0) ? u0_r : u1_r;
    end else begin
      iss_last = (k_r == KW'(STATE_ORDER - 1));
      iss_opnd = x_r[k_r];
    end
  end

  assign row_end_b = (kind_r == ssf_pkg::KIND_B) && iss_last &&
                     (row_r == KW'(STATE_ORDER - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r  <= ssf_pkg::KIND_C;
      row_r   <= '0;
      k_r     <= '0;
      a_ptr_r <= '0;
      b_ptr_r <= '0;
      c_ptr_r <= '0;
    end else if (smp_cmd) begin
      kind_r  <= ssf_pkg::KIND_C;
      row_r   <= '0;
      k_r     <= '0;
      a_ptr_r <= '0;
      b_ptr_r <= BASE_B;
      c_ptr_r <= BASE_C;
    end else if (issue) begin
      case (kind_r)
        ssf_pkg::KIND_C: c_ptr_r <= c_ptr_r + 1'b1;
        ssf_pkg::KIND_A: a_ptr_r <= a_ptr_r + 1'b1;
        default:         b_ptr_r <= b_ptr_r + 1'b1;
      endcase
      if (!iss_last) begin
        k_r <= k_r + 1'b1;
      end else begin
        k_r <= '0;
        case (kind_r)
          ssf_pkg::KIND_C: begin
            if (row_r == KW'(OUT_CHANNELS - 1)) begin
              kind_r <= ssf_pkg::KIND_A;
              row_r  <= '0;
            end else begin
              row_r <= row_r + 1'b1;
            end
          end
          ssf_pkg::KIND_A: kind_r <= ssf_pkg::KIND_B;
          default: begin
            kind_r <= ssf_pkg::KIND_A;
            row_r  <= row_r + 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
    end else begin
      ctl1_r.valid <= issue;
      ctl1_r.first <= (k_r == '0);
      ctl1_r.last  <= iss_last;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      op1_r <= iss_opnd;
    end
  end

  ssf_coef_mem u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (wr_cmd),
    .waddr (in_if.coef_index),
    .wdata (in_if.coef_value),
    .re    (issue),
    .raddr (iss_addr),
    .rdata (coef_rd)
  );

  ssf_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl1_r),
    .coef      (coef_rd),
    .opnd      ($signed(op1_r)),
    .res_valid (res_valid),
    .res       (res)
  );

  // ---------------------------------------------------------------- retire
  // Row results come back in issue order: C rows, then A row i, B row i pairs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ret_kind_r <= ssf_pkg::KIND_C;
      ret_row_r  <= '0;
    end else if (smp_cmd) begin
      ret_kind_r <= ssf_pkg::KIND_C;
      ret_row_r  <= '0;
    end else if (res_valid) begin
      case (ret_kind_r)
        ssf_pkg::KIND_C: begin
          if (ret_row_r == KW'(OUT_CHANNELS - 1)) begin
            ret_kind_r <= ssf_pkg::KIND_A;
            ret_row_r  <= '0;
          end else begin
            ret_row_r <= ret_row_r + 1'b1;
          end
        end
        ssf_pkg::KIND_A: ret_kind_r <= ssf_pkg::KIND_B;
        default: begin
          ret_kind_r <= ssf_pkg::KIND_A;
          ret_row_r  <= ret_row_r + 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      case (ret_kind_r)
        ssf_pkg::KIND_C: y_r[ret_row_r[0]] <= res;
        ssf_pkg::KIND_A: ax_r <= res;
        default:         nx_r[ret_row_r] <= ssf_pkg::sat_add(ax_r, res);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (smp_cmd) begin
      u0_r <= in_if.right_in;
      u1_r <= in_if.left_in;
    end
  end

  // Hold the old state until every A row has read it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STATE_ORDER; i++) begin
        x_r[i] <= '0;
      end
    end else if (commit) begin
      for (int i = 0; i < STATE_ORDER; i++) begin
        x_r[i] <= nx_r[i];
      end
    end
  end

  // ---------------------------------------------------------------- control
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (smp_cmd) state_nxt = S_RUN;
      S_RUN:   if (row_end_b) state_nxt = S_DRAIN;
      S_DRAIN: begin
        if (res_valid && (ret_kind_r == ssf_pkg::KIND_B) &&
            (ret_row_r == KW'(STATE_ORDER - 1))) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE:  if (commit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_xfer) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      right_out_r <= y_r[0];
      left_out_r  <= (OUT_CHANNELS > 1) ? y_r[1] : '0;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.right_out = $signed(right_out_r);
  assign out_if.left_out  = $signed(left_out_r);

`ifndef SYNTH
  a_sample_starts: assert property (@(posedge clk) disable iff (!rst_n)
    smp_cmd |=> (state_r == S_RUN))
    else $error("sample transfer did not start the sequencer");

  a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> ((state_r == S_RUN) || (state_r == S_DRAIN)))
    else $error("MAC row result outside a sample run");

  a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> (out_valid_r && (state_r == S_IDLE)))
    else $error("commit did not load the output register");

  a_no_write_during_run: assert property (@(posedge clk) disable iff (!rst_n)
    wr_cmd |-> !issue)
    else $error("coefficient write collided with a MAC read");

  a_drain_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |-> !issue)
    else $error("operand issued after the last row");
`endif

endmodule

// ===== sim/state_space_filter_q31_test.sv =====
// Self-checking testbench for state_space_filter_q31: coefficient writes and stereo samples
// against a cycle-free predictor of the Q31 state-space recursion.
// Depends on ssf_pkg, the channel interfaces in ssf_if and the filter RTL.
module state_space_filter_q31_test;

  localparam int N          = ssf_pkg::STATE_ORDER;
  localparam int NI         = ssf_pkg::IN_CHANNELS;
  localparam int NO         = ssf_pkg::OUT_CHANNELS;
  localparam int DEPTH      = ssf_pkg::STORE_DEPTH;
  localparam int BASE_B     = N * N;
  localparam int BASE_C     = BASE_B + N * NI;
  localparam int COEF_WORDS = BASE_C + NO * N;

  localparam logic [31:0] Q31_MAX   = 32'h7FFF_FFFF;
  localparam logic [31:0] Q31_MIN   = 32'h8000_0000;
  localparam longint      Q31_MAX_L = 64'sd2147483647;
  localparam longint      Q31_MIN_L = -64'sd2147483648;

  localparam int RANDOM_ITEMS = 1500;
  localparam int CALM_ITEMS   = 250;

  typedef struct packed {
    logic [31:0] right;
    logic [31:0] left;
  } out_pair_t;

  logic clk;
  logic rst_n;

  ssf_in_if  in_ch ();
  ssf_out_if out_ch ();

  state_space_filter_q31 dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // Mirror of the block's state
  logic [31:0] coef_mirror [DEPTH];
  logic [31:0] state_mirror [N];
  logic [31:0] u_vec [2];

  out_pair_t expected_outputs [$];

  int  error_count     = 0;
  int  results_checked = 0;
  int  writes_sent     = 0;
  int  samples_sent    = 0;
  int  commands_sent   = 0;
  bit  in_idle_on      = 1'b1;
  bit  out_idle_on     = 1'b1;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 1_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // One matrix row times state or input: 64-bit wrapping sum, bits 62..31 kept.
  function automatic logic [31:0] mac_row(input int base, input int len,
                                          input bit from_state);
    logic [63:0] acc;
    logic [31:0] opnd;
    longint      p;
    int          k;
    acc = '0;
    for (k = 0; k < len; k++) begin
      opnd = from_state ? state_mirror[k] : u_vec[k];
      p = longint'($signed(coef_mirror[(base + k) % DEPTH])) * longint'($signed(opnd));
      acc = acc + 64'(p);
    end
    return acc[62:31];
  endfunction

  function automatic logic [31:0] q31_sat_sum(input logic [31:0] a, input logic [31:0] b);
    longint s;
    s = longint'($signed(a)) + longint'($signed(b));
    if (s > Q31_MAX_L) return Q31_MAX;
    if (s < Q31_MIN_L) return Q31_MIN;
    return s[31:0];
  endfunction

  function automatic void advance_filter(input logic [31:0] r, input logic [31:0] l);
    logic [31:0] ax [N];
    logic [31:0] y [2];
    int          i;
    u_vec[0] = r;
    u_vec[1] = l;
    y[0] = '0;
    y[1] = '0;
    for (i = 0; i < NO && i < 2; i++) y[i] = mac_row(BASE_C + i * N, N, 1'b1);
    for (i = 0; i < N; i++) ax[i] = mac_row(i * N, N, 1'b1);
    for (i = 0; i < N; i++)
      state_mirror[i] = q31_sat_sum(ax[i], mac_row(BASE_B + i * NI, NI, 1'b0));
    expected_outputs.push_back('{right: y[0], left: y[1]});
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  task automatic send_command(input logic op, input logic [6:0] idx, input logic [31:0] val,
                              input logic [31:0] r, input logic [31:0] l);
    if (in_idle_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_ch.valid      = 1'b0;
      in_ch.opcode     = 1'($urandom_range(0, 1));
      in_ch.coef_index = 7'($urandom_range(0, 127));
      in_ch.coef_value = $urandom;
      in_ch.right_in   = $urandom;
      in_ch.left_in    = $urandom;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    @(negedge clk);
    in_ch.valid      = 1'b1;
    in_ch.opcode     = op;
    in_ch.coef_index = idx;
    in_ch.coef_value = val;
    in_ch.right_in   = r;
    in_ch.left_in    = l;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    commands_sent++;
    if (op == ssf_pkg::OP_WRITE) begin
      coef_mirror[idx] = val;
      writes_sent++;
    end else begin
      advance_filter(r, l);
      samples_sent++;
    end
  endtask

  task automatic write_coef(input int idx, input logic [31:0] val);
    send_command(ssf_pkg::OP_WRITE, 7'(idx % DEPTH), val, $urandom, $urandom);
  endtask

  task automatic run_sample(input logic [31:0] r, input logic [31:0] l);
    send_command(ssf_pkg::OP_SAMPLE, 7'($urandom_range(0, 127)), $urandom, r, l);
  endtask

  // Mostly random words with a heavy share of extremes; narrow keeps the random ones to |v| <= 2^24.
  function automatic logic [31:0] rand_q31(input bit narrow);
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 11))
      0: return Q31_MAX;
      1: return Q31_MIN;
      2: return '0;
      3: return {32{r[0]}} | 32'd1;
      default: return narrow ? {{7{r[24]}}, r[24:0]} : r;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  initial begin
    out_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (out_idle_on && $urandom_range(0, 15) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      out_ch.ready = 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    out_pair_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_outputs.size() == 0) begin
        $error("unexpected transfer: right_out %0d left_out %0d",
               out_ch.right_out, out_ch.left_out);
        error_count++;
      end else begin
        want = expected_outputs.pop_front();
        results_checked++;
        if (out_ch.right_out !== want.right) begin
          $error("right_out: expected %0d, got %0d", $signed(want.right), out_ch.right_out);
          error_count++;
        end
        if (out_ch.left_out !== want.left) begin
          $error("left_out: expected %0d, got %0d", $signed(want.left), out_ch.left_out);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Zero state gives zero output; writes past C change nothing.
  task automatic test_zero_state();
    run_sample(Q31_MAX, Q31_MIN);
    write_coef(DEPTH - 1, Q31_MIN);
    write_coef(COEF_WORDS, Q31_MAX);
    run_sample(Q31_MIN, Q31_MAX);
  endtask

  // Corner coefficients of every matrix; drive state 0 into saturation.
  task automatic test_extreme_coefs();
    write_coef(0, Q31_MAX);
    write_coef(N * N - 1, Q31_MIN);
    write_coef(BASE_B, Q31_MAX);
    write_coef(BASE_B + 1, Q31_MIN);
    write_coef(BASE_C - 1, Q31_MAX);
    write_coef(BASE_C, Q31_MAX);
    write_coef(BASE_C + N, Q31_MIN);
    write_coef(COEF_WORDS - 1, Q31_MAX);
    run_sample(Q31_MAX, '0);
    run_sample(Q31_MAX, '0);
    run_sample('0, Q31_MIN);
    run_sample('0, Q31_MIN);
    run_sample(Q31_MIN, Q31_MAX);
  endtask

  // Three products near 2^62 in one row overflow the 64-bit sum.
  task automatic test_accumulator_wrap();
    int i;
    for (i = 1; i <= 3; i++) begin
      write_coef(N + i, Q31_MIN);
      write_coef(BASE_B + i * NI, Q31_MAX);
    end
    run_sample(Q31_MIN, $urandom);
    run_sample(Q31_MIN, $urandom);
    run_sample(Q31_MAX, $urandom);
  endtask

  // Reload every coefficient word or 1 to 10 random store words, then run a burst of samples.
  task automatic run_program();
    int  k;
    int  offset;
    bit  narrow;
    narrow = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 3) == 0) begin
      offset = $urandom_range(0, COEF_WORDS - 1);
      for (k = 0; k < COEF_WORDS; k++) write_coef((k + offset) % COEF_WORDS, rand_q31(narrow));
    end else begin
      repeat ($urandom_range(1, 10)) write_coef($urandom_range(0, DEPTH - 1), rand_q31(narrow));
    end
    repeat ($urandom_range(3, 30)) run_sample(rand_q31(1'b0), rand_q31(1'b0));
  endtask

  task automatic test_random_programs();
    int stop_at;
    stop_at = commands_sent + RANDOM_ITEMS;
    while (commands_sent < stop_at) begin
      in_idle_on  = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      run_program();
    end
  endtask

  // Full rate on both sides to the end.
  task automatic test_back_to_back();
    int stop_at;
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    stop_at = commands_sent + CALM_ITEMS;
    while (commands_sent < stop_at) run_program();
  endtask

  initial begin
    int i;
    for (i = 0; i < DEPTH; i++) coef_mirror[i] = '0;
    for (i = 0; i < N; i++) state_mirror[i] = '0;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.opcode     = ssf_pkg::OP_WRITE;
    in_ch.coef_index = '0;
    in_ch.coef_value = '0;
    in_ch.right_in   = '0;
    in_ch.left_in    = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_zero_state();
    test_extreme_coefs();
    test_accumulator_wrap();
    test_random_programs();
    test_back_to_back();

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (expected_outputs.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);

    if (expected_outputs.size() != 0) begin
      $error("%0d expected results never arrived", expected_outputs.size());
      error_count++;
    end
    $display("Sent %0d coefficient writes and %0d stereo samples, %0d results compared.",
             writes_sent, samples_sent, results_checked);
    $display("Covered extreme coefficients, state saturation, sum overflow and random stalls.");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/ssf_pkg.sv
hw/rtl/ssf_if.sv
hw/rtl/ssf_coef_mem.sv
hw/rtl/ssf_mac.sv
hw/rtl/state_space_filter_q31.sv
sim/state_space_filter_q31_test.sv
